// ===== rtl/upd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, constants and the hex digit decode for the percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [7:0] C_PERCENT   = 8'h25;
    localparam logic [7:0] C_PLUS      = 8'h2B;
    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_MIN_PRINT = 8'd32;
    localparam logic [7:0] C_DEL       = 8'd127;

    typedef enum logic [3:0] {
        PH_PLAIN  = 4'b0001,
        PH_DIGIT1 = 4'b0010,
        PH_DIGIT2 = 4'b0100,
        PH_ERROR  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       is_end;
        logic       bad;
    } t_result;

    // {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/upd_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_in_reg
// Input register: holds one raw byte request until the decoder takes it.
// ----------------------------------------------------------------------------
module upd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char,
    input  logic       i_final,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_char,
    output logic       o_final
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_final;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_final = r_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char  <= i_char;
            r_final <= i_final;
        end
    end

endmodule

// ===== rtl/upd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_decode
// Escape phase machine and hex decode; state advances on each step.
// ----------------------------------------------------------------------------
module upd_decode
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    input  logic       i_final,
    output logic       o_has_result,
    output t_result    o_res
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_upper, n_upper;

    logic [4:0] hex;
    logic [7:0] byte_val;
    logic [7:0] ch;
    logic       have_char;

    always_comb begin
        hex       = hex_decode(i_char);
        byte_val  = {r_upper, hex[3:0]};
        ch        = 8'd0;
        have_char = 1'b0;
        n_phase   = r_phase;
        n_upper   = r_upper;
        unique case (r_phase)
            PH_PLAIN: begin
                if (i_char == C_PERCENT) begin
                    n_phase = PH_DIGIT1;
                end else begin
                    ch        = (i_char == C_PLUS) ? C_SPACE : i_char;
                    have_char = 1'b1;
                end
            end
            PH_DIGIT1: begin
                if (!hex[4]) begin
                    n_phase = PH_ERROR;
                end else begin
                    n_upper = hex[3:0];
                    n_phase = PH_DIGIT2;
                end
            end
            PH_DIGIT2: begin
                if (!hex[4]) begin
                    n_phase = PH_ERROR;
                end else if (byte_val >= C_MIN_PRINT && byte_val != C_DEL) begin
                    ch        = byte_val;
                    have_char = 1'b1;
                    n_phase   = PH_PLAIN;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_ERROR: begin
                n_phase = PH_ERROR;
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase

        o_has_result     = have_char || i_final;
        o_res.out_char   = ch;
        o_res.char_valid = have_char;
        o_res.is_end     = i_final;
        o_res.bad        = i_final && (n_phase != PH_PLAIN);

        if (i_final) begin
            n_phase = PH_PLAIN;
            n_upper = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_upper <= 4'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_upper <= n_upper;
        end
    end

endmodule

// ===== rtl/upd_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_out_reg
// Result register on the master side; frees itself when the result is taken.
// ----------------------------------------------------------------------------
module upd_out_reg
    import upd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/url_percent_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// Streaming URL percent decoder, one raw byte per request.
// Path: input request -> input reg -> phase machine -> result reg.
// Throughput: 1 byte per cycle unless a byte with a result waits on a stalled sink.
// Reset: synchronous active low; clears both stages and returns to plain text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module url_percent_decoder_unit
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_char
    input  logic       s_axis_tlast,  // in_final
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_char
    output logic [1:0] m_axis_tuser,  // [0] out_char_valid, [1] out_bad
    output logic       m_axis_tlast   // out_end
);

    logic       in_valid;
    logic [7:0] in_char;
    logic       in_final;
    logic       step;
    logic       has_result;
    logic       out_free;
    t_result    dec_res;
    t_result    out_res;

    assign step = in_valid && (!has_result || out_free);

    upd_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_char  (s_axis_tdata),
        .i_final (s_axis_tlast),
        .i_take  (step),
        .o_valid (in_valid),
        .o_char  (in_char),
        .o_final (in_final)
    );

    upd_decode u_dec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_char       (in_char),
        .i_final      (in_final),
        .o_has_result (has_result),
        .o_res        (dec_res)
    );

    upd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && has_result),
        .i_res   (dec_res),
        .o_free  (out_free),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tdata = out_res.out_char;
    assign m_axis_tuser = {out_res.bad, out_res.char_valid};
    assign m_axis_tlast = out_res.is_end;

endmodule

// ===== bench/tb_url_percent_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_url_percent_decoder_unit
// Self-checking bench for the streaming URL percent decoder. A behavioral
// decoder tracks the escape phase and predicts each decoded byte and each
// end-of-string marker. The results are compared field by field in arrival
// order. Directed strings come first, then random strings under changing
// source and sink idling, then a long sink stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder_unit;
    import upd_pkg::*;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_char
    logic       s_axis_tlast  = 1'b0;   // in_final
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_char
    logic [1:0] m_axis_tuser;           // [0] out_char_valid, [1] out_bad
    logic       m_axis_tlast;           // out_end

    t_phase     dec_phase  = PH_PLAIN;
    logic [3:0] dec_hi_nib = 4'h0;
    t_result    decoded_q[$];
    int         err_count  = 0;
    int         src_idle_pct = 0;
    int         rx_idle_pct  = 0;
    bit         stall_req    = 1'b0;
    int         stall_left   = 0;

    url_percent_decoder_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // -1 when the byte is not a hex digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10) return 8'("0" + nib);
        return lower ? 8'("a" + nib - 4'd10) : 8'("A" + nib - 4'd10);
    endfunction

    task automatic decode_byte(input logic [7:0] c, input logic fin);
        logic       have_char;
        logic [7:0] ch;
        int         d;
        t_result    res;
        have_char = 1'b0;
        ch = 8'h00;
        case (dec_phase)
            PH_PLAIN: begin
                if (c == C_PERCENT) begin
                    dec_phase = PH_DIGIT1;
                end else begin
                    ch = (c == C_PLUS) ? C_SPACE : c;
                    have_char = 1'b1;
                end
            end
            PH_DIGIT1: begin
                d = hex_nibble(c);
                if (d < 0) begin
                    dec_phase = PH_ERROR;
                end else begin
                    dec_hi_nib = 4'(d);
                    dec_phase = PH_DIGIT2;
                end
            end
            PH_DIGIT2: begin
                d = hex_nibble(c);
                if (d < 0) begin
                    dec_phase = PH_ERROR;
                end else begin
                    ch = {dec_hi_nib, 4'(d)};
                    if (ch >= C_MIN_PRINT && ch != C_DEL) begin
                        have_char = 1'b1;
                        dec_phase = PH_PLAIN;
                    end else begin
                        ch = 8'h00;
                        dec_phase = PH_ERROR;
                    end
                end
            end
            default: ;
        endcase
        if (have_char || fin) begin
            res.out_char   = have_char ? ch : 8'h00;
            res.char_valid = have_char;
            res.is_end     = fin;
            res.bad        = fin && (dec_phase != PH_PLAIN);
            decoded_q.push_back(res);
        end
        if (fin) begin
            dec_phase  = PH_PLAIN;
            dec_hi_nib = 4'h0;
        end
    endtask

    // entered and left just after a falling edge
    task automatic send_byte(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(c, fin);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_random_string(output int n_bytes);
        logic [7:0] text_q[$];
        int         tokens;
        int         v;
        if ($urandom_range(9) < 7) begin
            // well-formed: plain bytes, plus signs and printable escapes
            tokens = $urandom_range(1, 8);
            repeat (tokens) begin
                case ($urandom_range(3))
                    0: begin
                        v = $urandom_range(32, 255);
                        if (v == 127) v = 126;
                        text_q.push_back(C_PERCENT);
                        text_q.push_back(hex_char(4'(v >> 4), 1'($urandom_range(1))));
                        text_q.push_back(hex_char(4'(v), 1'($urandom_range(1))));
                    end
                    1: text_q.push_back(C_PLUS);
                    default: begin
                        v = $urandom_range(255);
                        text_q.push_back((8'(v) == C_PERCENT) ? C_PLUS : 8'(v));
                    end
                endcase
            end
        end else begin
            // noise: stray escapes, truncations, control and delete codes
            tokens = $urandom_range(1, 10);
            repeat (tokens) begin
                case ($urandom_range(3))
                    0: text_q.push_back(C_PERCENT);
                    1, 2: text_q.push_back(hex_char(4'($urandom_range(15)),
                                                    1'($urandom_range(1))));
                    default: text_q.push_back(8'($urandom_range(255)));
                endcase
            end
        end
        foreach (text_q[i]) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
        n_bytes = text_q.size();
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(C_PLUS, 1'b1);
        // escapes of both cases, the last one closing the string
        send_text("%4a%7E%20");
        // string ends right after the percent or the first digit, or on a bad first digit
        send_text("%");
        send_text("%4");
        send_text("%g");
        // decoded control code on the final byte
        send_text("%1f");
        // bad second digit, then swallowing
        send_text("%4gz");
        // delete code, then swallowing
        send_text("%7fab");
    endtask

    task automatic test_random(input int src_pct, input int rx_pct, input int n_items);
        int sent;
        int n;
        sent = 0;
        src_idle_pct = src_pct;
        rx_idle_pct  = rx_pct;
        while (sent < n_items) begin
            send_random_string(n);
            sent += n;
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        stall_req    = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_byte(8'($urandom_range(255)), i == 39);
        end
    endtask

    // sink side: random idling plus a long stall on request
    always @(negedge i_clk) begin
        if (stall_req) begin
            stall_req  = 1'b0;
            stall_left = 200;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result: out_char=%02h tuser=%b tlast=%b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                err_count++;
            end else begin
                exp_res = decoded_q.pop_front();
                if (m_axis_tdata !== exp_res.out_char) begin
                    $error("out_char: expected %02h, actual %02h",
                           exp_res.out_char, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tuser[0] !== exp_res.char_valid) begin
                    $error("out_char_valid: expected %b, actual %b",
                           exp_res.char_valid, m_axis_tuser[0]);
                    err_count++;
                end
                if (m_axis_tlast !== exp_res.is_end) begin
                    $error("out_end: expected %b, actual %b", exp_res.is_end, m_axis_tlast);
                    err_count++;
                end
                if (m_axis_tuser[1] !== exp_res.bad) begin
                    $error("out_bad: expected %b, actual %b", exp_res.bad, m_axis_tuser[1]);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        src_idle_pct = 7;
        rx_idle_pct  = 58;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(7, 58, 300);
        test_random(58, 7, 300);
        test_random(0, 0, 300);
        test_backpressure();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
